[hw/rtl/cdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdf_pkg: shared definitions for the chunk stream deframer
// Phase encoding, byte role, chunk kind and status codes, register indexes,
// reset values of the configuration registers and the bundles between modules.
// ----------------------------------------------------------------------------
package cdf_pkg;

    // Default width of the body length and the running LEB128 value.
    localparam int LEN_BITS_DEF = 32;

    // Magic, checksum and type bytes before the length field.
    localparam int HDR_BYTES = 9;

    // Reset values of the configuration registers.
    localparam logic [31:0] MAGIC_RST   = 32'd2238663299;
    localparam logic [7:0]  DOC_RST     = 8'd0;
    localparam logic [7:0]  CHANGE_RST  = 8'd1;
    localparam logic [7:0]  DEFLATE_RST = 8'd2;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_CHECK  = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_BODY   = 3'd4,
        PH_IGNORE = 3'd5
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_DOC     = 2'd1,
        CFG_CHANGE  = 2'd2,
        CFG_DEFLATE = 2'd3
    } t_cfg_idx;

    // Role of a byte within its chunk.
    localparam logic [2:0] ROLE_MAGIC  = 3'd0;
    localparam logic [2:0] ROLE_CHECK  = 3'd1;
    localparam logic [2:0] ROLE_TYPE   = 3'd2;
    localparam logic [2:0] ROLE_LEN    = 3'd3;
    localparam logic [2:0] ROLE_BODY   = 3'd4;
    localparam logic [2:0] ROLE_IGNORE = 3'd5;

    // Kind of the chunk.
    localparam logic [1:0] KIND_DOC     = 2'd0;
    localparam logic [1:0] KIND_CHANGE  = 2'd1;
    localparam logic [1:0] KIND_DEFLATE = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Status reported on the byte that stops parsing.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_MAGIC = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    // Configuration register contents.
    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  doc_type_code;
        logic [7:0]  change_type_code;
        logic [7:0]  deflate_type_code;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_role;
        logic [1:0] chunk_kind;
        logic       chunk_last;
        logic [2:0] status;
    } t_result;

    // Byte of the magic word expected at a position, first byte in the top bits.
    function automatic logic [7:0] magic_byte(input logic [31:0] word, input logic [1:0] pos);
        logic [7:0] sel;
        unique case (pos)
            2'd0:    sel = word[31:24];
            2'd1:    sel = word[23:16];
            2'd2:    sel = word[15:8];
            default: sel = word[7:0];
        endcase
        return sel;
    endfunction

endpackage

[hw/rtl/cdf_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdf_cfg_regs: configuration register file
// Holds the magic word and the three type codes; one write per transaction.
// ----------------------------------------------------------------------------
module cdf_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output cdf_pkg::t_cfg   o_cfg
);

    cdf_pkg::t_cfg r_cfg;

    // Register writes; every index names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word        <= cdf_pkg::MAGIC_RST;
            r_cfg.doc_type_code     <= cdf_pkg::DOC_RST;
            r_cfg.change_type_code  <= cdf_pkg::CHANGE_RST;
            r_cfg.deflate_type_code <= cdf_pkg::DEFLATE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cdf_pkg::CFG_MAGIC:   r_cfg.magic_word        <= i_cfg_data;
                cdf_pkg::CFG_DOC:     r_cfg.doc_type_code     <= i_cfg_data[7:0];
                cdf_pkg::CFG_CHANGE:  r_cfg.change_type_code  <= i_cfg_data[7:0];
                default:              r_cfg.deflate_type_code <= i_cfg_data[7:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/cdf_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdf_parser: chunk header and length parser
// Holds the parse state and works out the tags of one byte per step.
// ----------------------------------------------------------------------------
module cdf_parser #(
    parameter int LEN_BITS = cdf_pkg::LEN_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  cdf_pkg::t_cfg     i_cfg,
    output cdf_pkg::t_result  o_res
);

    localparam int SHW = $clog2(LEN_BITS + 7);
    localparam int CNW = $clog2(LEN_BITS / 7 + 2);
    localparam int WW  = LEN_BITS + 7;
    localparam logic [LEN_BITS-1:0] LIMIT = '1;

    cdf_pkg::t_phase       r_phase, n_phase;
    logic [3:0]            r_hdr, n_hdr;
    logic [LEN_BITS-1:0]   r_accum, n_accum;
    logic [SHW-1:0]        r_shift, n_shift;
    logic [CNW-1:0]        r_cnt, n_cnt;
    logic [LEN_BITS-1:0]   r_body, n_body;
    logic [1:0]            r_kind, n_kind;

    logic [1:0]            magic_pos;
    logic [1:0]            type_kind;
    logic [WW-1:0]         group_shifted;
    logic                  group_ovf;
    logic [LEN_BITS-1:0]   merged;
    logic [LEN_BITS-1:0]   len_max;
    logic [LEN_BITS-1:0]   body_dec;
    cdf_pkg::t_result      res;

    // Datapath pieces shared by the phases.
    always_comb begin
        magic_pos     = r_hdr[1:0];
        group_shifted = WW'(i_byte[6:0]) << r_shift;
        group_ovf     = (r_shift >= SHW'(LEN_BITS)) ||
                        (group_shifted[WW-1:LEN_BITS] != '0);
        merged        = r_accum | group_shifted[LEN_BITS-1:0];
        // Largest body length that keeps the whole chunk size representable.
        len_max       = LIMIT - (LEN_BITS'(cdf_pkg::HDR_BYTES + 1) + LEN_BITS'(r_cnt));
        body_dec      = (r_body != '0) ? (r_body - LEN_BITS'(1)) : '0;
        // Type code match, document first.
        priority if (i_byte == i_cfg.doc_type_code)     type_kind = cdf_pkg::KIND_DOC;
        else if     (i_byte == i_cfg.change_type_code)  type_kind = cdf_pkg::KIND_CHANGE;
        else if     (i_byte == i_cfg.deflate_type_code) type_kind = cdf_pkg::KIND_DEFLATE;
        else                                            type_kind = cdf_pkg::KIND_NONE;
    end

    // Next parse state and the tags of the current byte.
    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_accum = r_accum;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_body  = r_body;
        n_kind  = r_kind;
        res.out_byte   = i_byte;
        res.byte_role  = cdf_pkg::ROLE_IGNORE;
        res.chunk_kind = cdf_pkg::KIND_NONE;
        res.chunk_last = 1'b0;
        res.status     = cdf_pkg::ST_OK;

        unique case (r_phase)
            cdf_pkg::PH_MAGIC: begin
                if (i_byte != cdf_pkg::magic_byte(i_cfg.magic_word, magic_pos)) begin
                    res.status = cdf_pkg::ST_NO_MAGIC;
                    n_phase    = cdf_pkg::PH_IGNORE;
                end else begin
                    res.byte_role = cdf_pkg::ROLE_MAGIC;
                    if (i_end) begin
                        res.status = (magic_pos == 2'd3) ? cdf_pkg::ST_SHORT
                                                         : cdf_pkg::ST_NO_MAGIC;
                    end
                    n_hdr = {2'b00, magic_pos} + 4'd1;
                    if (magic_pos == 2'd3) begin
                        n_phase = cdf_pkg::PH_CHECK;
                    end
                end
            end
            cdf_pkg::PH_CHECK: begin
                res.byte_role = cdf_pkg::ROLE_CHECK;
                if (i_end) begin
                    res.status = cdf_pkg::ST_SHORT;
                end
                n_hdr = r_hdr + 4'd1;
                if (n_hdr >= 4'd8) begin
                    n_phase = cdf_pkg::PH_TYPE;
                end
            end
            cdf_pkg::PH_TYPE: begin
                res.byte_role  = cdf_pkg::ROLE_TYPE;
                res.chunk_kind = type_kind;
                n_kind         = type_kind;
                if (i_end) begin
                    res.status = cdf_pkg::ST_SHORT;
                end else if (type_kind == cdf_pkg::KIND_NONE) begin
                    res.status = cdf_pkg::ST_BAD_TYPE;
                    n_phase    = cdf_pkg::PH_IGNORE;
                end else begin
                    n_phase = cdf_pkg::PH_LEN;
                    n_accum = '0;
                    n_shift = '0;
                    n_cnt   = '0;
                end
            end
            cdf_pkg::PH_LEN: begin
                res.byte_role  = cdf_pkg::ROLE_LEN;
                res.chunk_kind = r_kind;
                if (group_ovf) begin
                    res.status = cdf_pkg::ST_OVERFLOW;
                    n_phase    = cdf_pkg::PH_IGNORE;
                end else begin
                    n_accum = merged;
                    if (i_byte[7]) begin
                        // Continuation group: more length bytes follow.
                        n_shift = r_shift + SHW'(7);
                        n_cnt   = r_cnt + CNW'(1);
                        if (i_end) begin
                            res.status = cdf_pkg::ST_SHORT;
                        end
                    end else if (merged > len_max) begin
                        res.status = cdf_pkg::ST_OVERFLOW;
                        n_phase    = cdf_pkg::PH_IGNORE;
                    end else if (merged == '0) begin
                        // Empty body: this length byte closes the chunk.
                        res.chunk_last = 1'b1;
                        n_phase        = cdf_pkg::PH_MAGIC;
                        n_hdr          = 4'd0;
                        n_kind         = cdf_pkg::KIND_NONE;
                    end else if (i_end) begin
                        res.status = cdf_pkg::ST_TRUNC;
                    end else begin
                        n_body  = merged;
                        n_phase = cdf_pkg::PH_BODY;
                    end
                end
            end
            cdf_pkg::PH_BODY: begin
                res.byte_role  = cdf_pkg::ROLE_BODY;
                res.chunk_kind = r_kind;
                n_body         = body_dec;
                if (body_dec == '0) begin
                    res.chunk_last = 1'b1;
                    n_phase        = cdf_pkg::PH_MAGIC;
                    n_hdr          = 4'd0;
                    n_kind         = cdf_pkg::KIND_NONE;
                end else if (i_end) begin
                    res.status = cdf_pkg::ST_TRUNC;
                end
            end
            cdf_pkg::PH_IGNORE: begin
                n_phase = cdf_pkg::PH_IGNORE;
            end
            default: begin
                n_phase = cdf_pkg::PH_IGNORE;
            end
        endcase

        // The last byte of a stream returns the parser to its start.
        if (i_end) begin
            n_phase = cdf_pkg::PH_MAGIC;
            n_hdr   = 4'd0;
            n_accum = '0;
            n_shift = '0;
            n_cnt   = '0;
            n_body  = '0;
            n_kind  = cdf_pkg::KIND_NONE;
        end
    end

    // Parse state register, advanced once per byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cdf_pkg::PH_MAGIC;
            r_hdr   <= 4'd0;
            r_accum <= '0;
            r_shift <= '0;
            r_cnt   <= '0;
            r_body  <= '0;
            r_kind  <= cdf_pkg::KIND_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_accum <= n_accum;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_body  <= n_body;
            r_kind  <= n_kind;
        end
    end

    assign o_res = res;

endmodule

[hw/rtl/chunk_stream_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_stream_deframer: byte stream chunk deframer
// Splits a byte stream into magic, checksum, type, LEB128 length and body
// and tags every byte with its role, its chunk kind and a stop status.
//
// Input channel: one stream byte with its end-of-stream flag per transaction.
// Output channel: exactly one tagged byte per input byte, in order.
// Configuration channel: one register write per transaction (magic word and
// the three type codes); it is always ready. The user must use it only while
// idle; the block itself does not enforce this. An accepted byte is held in
// the input register, then moves into the result register and is offered
// from there. Throughput is one byte per clock while the receiver takes every
// result, as cdf_parser advances its parse state once per byte.
// Reset loads the default magic word and type codes and puts the parser at
// the start of a chunk. When the receiver stalls, the result register holds,
// the input register takes one more byte, and then input ready drops until
// the result is taken.
// ----------------------------------------------------------------------------
module chunk_stream_deframer #(
    parameter int LEN_BITS = cdf_pkg::LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_stream_end,
    // Tagged output stream.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_byte_role,
    output logic [1:0]  o_chunk_kind,
    output logic        o_chunk_last,
    output logic [2:0]  o_status,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_end;
    logic               r_out_valid;
    cdf_pkg::t_result   r_out;
    logic               advance;
    cdf_pkg::t_cfg      cfg;
    cdf_pkg::t_result   res;

    assign o_cfg_ready = 1'b1;

    cdf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // A byte moves from the input register into the result register.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    cdf_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_stream_end;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_byte_role  = r_out.byte_role;
    assign o_chunk_kind = r_out.chunk_kind;
    assign o_chunk_last = r_out.chunk_last;
    assign o_status     = r_out.status;

    // A waiting input byte is never dropped while the output is stalled.
    a_in_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input byte lost while stalled");

    // Only a length or body byte can close a chunk.
    a_last_role : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_chunk_last) |->
        (o_byte_role == cdf_pkg::ROLE_LEN || o_byte_role == cdf_pkg::ROLE_BODY))
        else $error("chunk end on a header byte");

    // An unknown type is flagged on the type byte, with no kind.
    a_bad_type : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cdf_pkg::ST_BAD_TYPE) |->
        (o_byte_role == cdf_pkg::ROLE_TYPE && o_chunk_kind == cdf_pkg::KIND_NONE))
        else $error("bad type status on a wrong byte");

    // Magic, checksum and ignored bytes carry no chunk kind.
    a_kind_none : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_role == cdf_pkg::ROLE_MAGIC ||
                         o_byte_role == cdf_pkg::ROLE_CHECK ||
                         o_byte_role == cdf_pkg::ROLE_IGNORE)) |->
        (o_chunk_kind == cdf_pkg::KIND_NONE))
        else $error("chunk kind set on a header or ignored byte");

endmodule
